FILE: design/cwmq_pkg.sv
// Shared widths, codes and parameter defaults for the clipped window mean core.
`default_nettype none
package cwmq_pkg;

   // parameter defaults
   localparam int DEF_MAX_COLUMNS = 256;
   localparam int DEF_MAX_ROWS    = 256;
   localparam int DEF_HALF_WINDOW = 11;

   // fixed field widths
   localparam int COORD_W     = 12;
   localparam int PIXEL_W     = 8;
   localparam int DIM_W       = 9;
   localparam int RSP_SUM_W   = 18;
   localparam int RSP_COUNT_W = 10;
   localparam int RSP_MEAN_W  = 17;
   localparam int FRAC_W      = 16;
   localparam int CSR_INDEX_W = 1;

   // full row-major address before truncation to the store depth
   localparam int FULL_ADDR_W = 2 * COORD_W + 1;

   localparam logic [DIM_W-1:0] MAP_DIM_RESET = 9'd256;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_COLUMNS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAP_ROWS    = 1'd1;

endpackage
`default_nettype wire

FILE: design/clipped_window_mean_query_core.sv
// Top level: pixel store, window scan sequencer and serial divider for the window mean.
// A write beat never raises busy. A query beat keeps busy high while the window is scanned
// through the single store read port (one pixel a cycle) and the mean is formed by the
// one-bit-a-cycle restoring divider; an empty window skips the divider. The result strobe
// is high for one cycle, in the last busy state (ST_DONE); the receiver cannot stall.
// Reset clears control and sets both map sizes to 256; store contents are unknown until
// written.
`default_nettype none
module clipped_window_mean_query_core #(
   parameter int MAX_COLUMNS = cwmq_pkg::DEF_MAX_COLUMNS,
   parameter int MAX_ROWS    = cwmq_pkg::DEF_MAX_ROWS,
   parameter int HALF_WINDOW = cwmq_pkg::DEF_HALF_WINDOW
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 start,
   output logic                                      busy,
   input  wire logic                                 req_operation,
   input  wire logic signed [cwmq_pkg::COORD_W-1:0]  req_x_coord,
   input  wire logic signed [cwmq_pkg::COORD_W-1:0]  req_y_coord,
   input  wire logic [cwmq_pkg::PIXEL_W-1:0]         req_pixel_value,
   output logic                                      rsp_valid,
   output logic [cwmq_pkg::RSP_SUM_W-1:0]            rsp_window_sum,
   output logic [cwmq_pkg::RSP_COUNT_W-1:0]          rsp_pixel_count,
   output logic [cwmq_pkg::RSP_MEAN_W-1:0]           rsp_mean_fraction,
   output logic                                      rsp_window_empty,
   input  wire logic                                 csr_write,
   input  wire logic [cwmq_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [cwmq_pkg::DIM_W-1:0]           csr_wdata
);
   import cwmq_pkg::*;

   localparam int DEPTH      = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WIN_SIDE   = 2 * HALF_WINDOW + 1;
   localparam int WIN_AREA   = WIN_SIDE * WIN_SIDE;
   localparam int WIN_CNT_W  = (WIN_SIDE > 1) ? $clog2(WIN_SIDE) : 1;
   localparam int COUNT_W    = $clog2(WIN_AREA + 1);
   localparam int SUM_W      = $clog2(WIN_AREA * 255 + 1);
   localparam int NUM_W      = SUM_W + FRAC_W;
   localparam int DEN_W      = COUNT_W + PIXEL_W;
   localparam int STEP_W     = $clog2(NUM_W + 1);
   localparam int POS_W      = COORD_W + 1;

   localparam logic signed [POS_W-1:0]   HALF_S   = POS_W'(HALF_WINDOW);
   localparam logic [POS_W-1:0]          MAX_COL_L = POS_W'(MAX_COLUMNS);
   localparam logic [POS_W-1:0]          MAX_ROW_L = POS_W'(MAX_ROWS);
   localparam logic [WIN_CNT_W-1:0]      WIN_LAST  = WIN_CNT_W'(WIN_SIDE - 1);
   localparam logic [FULL_ADDR_W-1:0]    ROW_PITCH = FULL_ADDR_W'(MAX_COLUMNS);
   localparam logic [STEP_W-1:0]         NUM_STEPS = STEP_W'(NUM_W);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_SCAN   = 6'b000010,
      ST_DRAIN  = 6'b000100,
      ST_PREP   = 6'b001000,
      ST_DIVIDE = 6'b010000,
      ST_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [DIM_W-1:0] map_columns_ff, map_rows_ff;

   logic signed [POS_W-1:0] cx_ff, cx_in;
   logic signed [POS_W-1:0] px_ff, px_in, py_ff, py_in;
   logic [WIN_CNT_W-1:0]    col_ff, col_in, row_ff, row_in;

   logic                    hit_ff, hit_in;
   logic [PIXEL_W-1:0]      rd_data_ff;
   logic [SUM_W-1:0]        sum_ff, sum_in;
   logic [COUNT_W-1:0]      count_ff, count_in;

   logic [NUM_W-1:0]        num_ff, num_in;
   logic [NUM_W-1:0]        quot_ff, quot_in;
   logic [DEN_W-1:0]        den_ff, den_in;
   logic [DEN_W-1:0]        rem_ff, rem_in;
   logic [STEP_W-1:0]       step_ff, step_in;

   logic [PIXEL_W-1:0]      store_mem [DEPTH];

   logic                    accept;
   logic                    wr_en;
   logic [FULL_ADDR_W-1:0]  wr_addr_full, rd_addr_full;
   logic [POS_W-1:0]        cols_lim, rows_lim;
   logic                    in_map;
   logic [DEN_W:0]          trial;
   logic                    trial_ge;
   logic [SUM_W+RSP_SUM_W-1:0]     sum_wide;
   logic [COUNT_W+RSP_COUNT_W-1:0] count_wide;

   assign accept = start && !busy;
   assign busy   = (state_ff != ST_IDLE);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         map_columns_ff <= MAP_DIM_RESET;
         map_rows_ff    <= MAP_DIM_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_MAP_COLUMNS: map_columns_ff <= csr_wdata;
            CSR_MAP_ROWS:    map_rows_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // map size clipped to the store
   always_comb begin
      cols_lim = POS_W'(map_columns_ff);
      rows_lim = POS_W'(map_rows_ff);
      if (cols_lim > MAX_COL_L) cols_lim = MAX_COL_L;
      if (rows_lim > MAX_ROW_L) rows_lim = MAX_ROW_L;
   end

   // write beat: coordinates must lie inside the store
   assign wr_en = accept && (req_operation == OP_WRITE)
                  && !req_x_coord[COORD_W-1] && !req_y_coord[COORD_W-1]
                  && (POS_W'(req_x_coord[COORD_W-2:0]) < MAX_COL_L)
                  && (POS_W'(req_y_coord[COORD_W-2:0]) < MAX_ROW_L);

   assign wr_addr_full = FULL_ADDR_W'(req_y_coord[COORD_W-2:0]) * ROW_PITCH
                       + FULL_ADDR_W'(req_x_coord[COORD_W-2:0]);

   // scan address; only meaningful when in_map
   assign rd_addr_full = FULL_ADDR_W'(py_ff[COORD_W-1:0]) * ROW_PITCH
                       + FULL_ADDR_W'(px_ff[COORD_W-1:0]);

   assign in_map = !px_ff[POS_W-1] && !py_ff[POS_W-1]
                   && ({1'b0, px_ff[COORD_W-1:0]} < cols_lim)
                   && ({1'b0, py_ff[COORD_W-1:0]} < rows_lim);

   always_ff @(posedge clock) begin
      if (wr_en) store_mem[wr_addr_full[ADDR_W-1:0]] <= req_pixel_value;
      rd_data_ff <= store_mem[rd_addr_full[ADDR_W-1:0]];
   end

   // divider step: shift in the next dividend bit, subtract if it fits
   assign trial    = {rem_ff, num_ff[NUM_W-1]};
   assign trial_ge = (trial >= {1'b0, den_ff});

   always_comb begin
      state_in = state_ff;
      cx_in    = cx_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      hit_in   = 1'b0;
      sum_in   = sum_ff;
      count_in = count_ff;
      num_in   = num_ff;
      quot_in  = quot_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      step_in  = step_ff;

      // pixel read last cycle lands here
      if (hit_ff) begin
         sum_in   = sum_ff + SUM_W'(rd_data_ff);
         count_in = count_ff + COUNT_W'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_operation == OP_QUERY)) begin
               cx_in    = POS_W'(req_x_coord) - HALF_S;
               px_in    = POS_W'(req_x_coord) - HALF_S;
               py_in    = POS_W'(req_y_coord) - HALF_S;
               col_in   = '0;
               row_in   = '0;
               sum_in   = '0;
               count_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            hit_in = in_map;
            if (col_ff == WIN_LAST) begin
               col_in = '0;
               px_in  = cx_ff;
               py_in  = py_ff + POS_W'(1);
               row_in = row_ff + WIN_CNT_W'(1);
               if (row_ff == WIN_LAST) state_in = ST_DRAIN;
            end else begin
               col_in = col_ff + WIN_CNT_W'(1);
               px_in  = px_ff + POS_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_PREP;
         end
         ST_PREP: begin
            num_in  = {sum_ff, FRAC_W'(0)};
            den_in  = DEN_W'({count_ff, PIXEL_W'(0)}) - DEN_W'(count_ff);
            rem_in  = '0;
            quot_in = '0;
            step_in = NUM_STEPS;
            state_in = (count_ff == '0) ? ST_DONE : ST_DIVIDE;
         end
         ST_DIVIDE: begin
            num_in  = {num_ff[NUM_W-2:0], 1'b0};
            quot_in = {quot_ff[NUM_W-2:0], trial_ge};
            rem_in  = trial_ge ? DEN_W'(trial - {1'b0, den_ff}) : trial[DEN_W-1:0];
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) state_in = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         hit_ff   <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff    <= cx_in;
      px_ff    <= px_in;
      py_ff    <= py_in;
      col_ff   <= col_in;
      row_ff   <= row_in;
      sum_ff   <= sum_in;
      count_ff <= count_in;
      num_ff   <= num_in;
      quot_ff  <= quot_in;
      den_ff   <= den_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
   end

   // result beat; sum and count are reported masked to the field widths
   assign sum_wide   = (SUM_W + RSP_SUM_W)'(sum_ff);
   assign count_wide = (COUNT_W + RSP_COUNT_W)'(count_ff);

   assign rsp_valid         = (state_ff == ST_DONE);
   assign rsp_window_empty  = (count_ff == '0);
   assign rsp_window_sum    = sum_wide[RSP_SUM_W-1:0];
   assign rsp_pixel_count   = count_wide[RSP_COUNT_W-1:0];
   assign rsp_mean_fraction = rsp_window_empty ? '0 : quot_ff[RSP_MEAN_W-1:0];

endmodule
`default_nettype wire
